FILE: rtl/core/stt_pkg.sv
package stt_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 16;
  localparam int unsigned LineW  = 32;
  localparam int unsigned ClassW = 3;
  localparam int unsigned NSlot  = 2;
  localparam int unsigned QueueDepthDefault = 4;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgMaxBytes   = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgCountLines = 8'd1;
  localparam logic [CountW-1:0]  MaxBytesReset = 16'd4096;

  localparam logic [ByteW-1:0] ChNewline   = 8'h0a;
  localparam logic [ByteW-1:0] ChBackslash = 8'h5c;
  localparam logic [ByteW-1:0] ChStar      = 8'h2a;
  localparam logic [ByteW-1:0] ChSlash     = 8'h2f;
  localparam logic [ByteW-1:0] ChDquote    = 8'h22;
  localparam logic [ByteW-1:0] ChSquote    = 8'h27;

  typedef enum logic [3:0] {
    PH_IDLE, PH_SPACE, PH_ALPHA, PH_DIGIT, PH_STR, PH_STR_ESC,
    PH_SLASH, PH_BLOCK, PH_BLOCK_STAR, PH_LINE
  } phase_e;

  typedef enum logic [ClassW-1:0] {
    CL_SPACE, CL_ALPHA, CL_DIGIT, CL_STRING, CL_COMMENT, CL_SINGLE, CL_EOI
  } class_e;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             byte_valid;
    class_e           token_class;
    logic             token_end;
    logic             truncated;
    logic [LineW-1:0] line_number;
  } res_t;

  typedef struct packed {
    logic [1:0]           cnt;
    res_t [NSlot-1:0]     res;
  } bundle_t;

  function automatic logic is_space(logic [ByteW-1:0] b);
    return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_alpha(logic [ByteW-1:0] b);
    return (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a);
  endfunction

  function automatic logic is_digit(logic [ByteW-1:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

endpackage

FILE: rtl/core/stt_front.sv
module stt_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [stt_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [stt_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        in_mode_i,
  input  logic [stt_pkg::ByteW-1:0]   in_byte_i,
  output logic                        push_o,
  output stt_pkg::bundle_t            bundle_o,
  input  logic                        full_i
);
  import stt_pkg::*;

  typedef struct packed {
    phase_e              phase;
    logic [ByteW-1:0]    held;
    logic                hv;
    class_e              cls;
    logic [ByteW-1:0]    delim;
    logic [CountW-1:0]   bytes;
    logic [LineW-1:0]    nl;
    logic                cut;
    logic [1:0]          n;
    res_t [NSlot-1:0]    res;
  } scan_t;

  logic [CountW-1:0] max_q;
  logic              cl_q;
  scan_t             cur, nxt;
  phase_e            phase_q;
  logic [ByteW-1:0]  held_q, delim_q;
  logic              hv_q, cut_q;
  class_e            cls_q;
  logic [CountW-1:0] bytes_q;
  logic [LineW-1:0]  nl_q;

  function automatic scan_t put(scan_t s, logic [ByteW-1:0] b, logic v, class_e c, logic e);
    res_t r;
    r.out_byte    = b;
    r.byte_valid  = v;
    r.token_class = c;
    r.token_end   = e;
    r.truncated   = s.cut;
    r.line_number = s.nl;
    s.res[s.n[0]] = r;
    s.n = s.n + 2'd1;
    return s;
  endfunction

  function automatic scan_t give(scan_t s, logic [ByteW-1:0] b, logic e,
                                 logic [CountW-1:0] mx);
    if (s.bytes < mx) begin
      s.bytes = s.bytes + 16'd1;
      s = put(s, b, 1'b1, s.cls, e);
    end else begin
      s.cut = 1'b1;
      if (e) s = put(s, 8'd0, 1'b0, s.cls, 1'b1);
    end
    return s;
  endfunction

  function automatic scan_t extend(scan_t s, logic [ByteW-1:0] b, logic [CountW-1:0] mx);
    if (s.bytes < mx) begin
      s.bytes = s.bytes + 16'd1;
      if (s.hv) s = put(s, s.held, 1'b1, s.cls, 1'b0);
      s.held = b;
      s.hv = 1'b1;
    end else begin
      s.cut = 1'b1;
    end
    return s;
  endfunction

  function automatic scan_t count_nl(scan_t s, logic [ByteW-1:0] b, logic cl);
    if (b == ChNewline && cl) s.nl = s.nl + 32'd1;
    return s;
  endfunction

  function automatic scan_t end_run(scan_t s);
    if (s.hv) s = put(s, s.held, 1'b1, s.cls, 1'b1);
    else s = put(s, 8'd0, 1'b0, s.cls, 1'b1);
    s.hv = 1'b0;
    s.phase = PH_IDLE;
    return s;
  endfunction

  function automatic scan_t start_token(scan_t s, logic [ByteW-1:0] b,
                                        logic [CountW-1:0] mx, logic cl);
    s.bytes = '0;
    s.cut = 1'b0;
    s.hv = 1'b0;
    if (is_space(b) || is_alpha(b) || is_digit(b) || b == ChSlash) begin
      if (is_space(b)) begin
        s.phase = PH_SPACE; s.cls = CL_SPACE;
      end else if (is_alpha(b)) begin
        s.phase = PH_ALPHA; s.cls = CL_ALPHA;
      end else if (is_digit(b)) begin
        s.phase = PH_DIGIT; s.cls = CL_DIGIT;
      end else begin
        s.phase = PH_SLASH; s.cls = CL_SINGLE;
      end
      s = extend(s, b, mx);
      if (s.phase == PH_SPACE) s = count_nl(s, b, cl);
    end else if (b == ChDquote || b == ChSquote) begin
      s.phase = PH_STR;
      s.cls = CL_STRING;
      s.delim = b;
      s = give(s, b, 1'b0, mx);
    end else begin
      s.phase = PH_IDLE;
      s.cls = CL_SINGLE;
      s = give(s, b, 1'b1, mx);
    end
    return s;
  endfunction

  always_comb begin
    cur = '0;
    cur.phase = phase_q;
    cur.held  = held_q;
    cur.hv    = hv_q;
    cur.cls   = cls_q;
    cur.delim = delim_q;
    cur.bytes = bytes_q;
    cur.nl    = nl_q;
    cur.cut   = cut_q;
  end

  always_comb begin
    nxt = cur;
    if (in_mode_i) begin
      unique case (cur.phase)
        PH_SPACE, PH_ALPHA, PH_DIGIT, PH_SLASH, PH_LINE: nxt = end_run(nxt);
        PH_STR, PH_STR_ESC: nxt = give(nxt, nxt.delim, 1'b1, max_q);
        PH_BLOCK, PH_BLOCK_STAR: nxt = give(nxt, ChSlash, 1'b1, max_q);
        default: ;
      endcase
      nxt.phase = PH_IDLE;
      nxt.hv = 1'b0;
      nxt.bytes = '0;
      nxt.cut = 1'b0;
      nxt = put(nxt, 8'd0, 1'b0, CL_EOI, 1'b1);
    end else begin
      unique case (cur.phase)
        PH_SPACE: begin
          if (is_space(in_byte_i)) begin
            nxt = extend(nxt, in_byte_i, max_q);
            nxt = count_nl(nxt, in_byte_i, cl_q);
          end else begin
            nxt = end_run(nxt);
            nxt = start_token(nxt, in_byte_i, max_q, cl_q);
          end
        end
        PH_ALPHA: begin
          if (is_alpha(in_byte_i)) nxt = extend(nxt, in_byte_i, max_q);
          else begin
            nxt = end_run(nxt);
            nxt = start_token(nxt, in_byte_i, max_q, cl_q);
          end
        end
        PH_DIGIT: begin
          if (is_digit(in_byte_i)) nxt = extend(nxt, in_byte_i, max_q);
          else begin
            nxt = end_run(nxt);
            nxt = start_token(nxt, in_byte_i, max_q, cl_q);
          end
        end
        PH_LINE: begin
          if (in_byte_i != ChNewline) nxt = extend(nxt, in_byte_i, max_q);
          else begin
            nxt = end_run(nxt);
            nxt = start_token(nxt, in_byte_i, max_q, cl_q);
          end
        end
        PH_SLASH: begin
          if (in_byte_i == ChStar) begin
            nxt.cls = CL_COMMENT;
            if (nxt.hv) nxt = put(nxt, nxt.held, 1'b1, CL_COMMENT, 1'b0);
            nxt.hv = 1'b0;
            nxt = give(nxt, in_byte_i, 1'b0, max_q);
            nxt.phase = PH_BLOCK;
          end else if (in_byte_i == ChSlash) begin
            nxt.cls = CL_COMMENT;
            nxt.phase = PH_LINE;
            nxt = extend(nxt, in_byte_i, max_q);
          end else begin
            nxt = end_run(nxt);
            nxt = start_token(nxt, in_byte_i, max_q, cl_q);
          end
        end
        PH_STR: begin
          if (in_byte_i == cur.delim) begin
            nxt = give(nxt, in_byte_i, 1'b1, max_q);
            nxt.phase = PH_IDLE;
          end else begin
            nxt = give(nxt, in_byte_i, 1'b0, max_q);
            if (in_byte_i == ChBackslash) nxt.phase = PH_STR_ESC;
          end
        end
        PH_STR_ESC: begin
          nxt = give(nxt, in_byte_i, 1'b0, max_q);
          nxt.phase = PH_STR;
        end
        PH_BLOCK: begin
          nxt = give(nxt, in_byte_i, 1'b0, max_q);
          if (in_byte_i == ChStar) nxt.phase = PH_BLOCK_STAR;
        end
        PH_BLOCK_STAR: begin
          if (in_byte_i == ChSlash) begin
            nxt = give(nxt, in_byte_i, 1'b1, max_q);
            nxt.phase = PH_IDLE;
          end else begin
            nxt = give(nxt, in_byte_i, 1'b0, max_q);
            if (in_byte_i != ChStar) nxt.phase = PH_BLOCK;
          end
        end
        default: nxt = start_token(nxt, in_byte_i, max_q, cl_q);
      endcase
    end
  end

  assign in_ready_o = !full_i;
  assign push_o = in_valid_i && in_ready_o && (nxt.n != 2'd0);
  assign bundle_o.cnt = nxt.n;
  assign bundle_o.res = nxt.res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxBytesReset;
      cl_q  <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgMaxBytes) max_q <= cfg_data_i;
      else if (cfg_index_i == CfgCountLines) cl_q <= cfg_data_i[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      held_q  <= '0;
      hv_q    <= 1'b0;
      cls_q   <= CL_SPACE;
      delim_q <= '0;
      bytes_q <= '0;
      nl_q    <= '0;
      cut_q   <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      phase_q <= nxt.phase;
      held_q  <= nxt.held;
      hv_q    <= nxt.hv;
      cls_q   <= nxt.cls;
      delim_q <= nxt.delim;
      bytes_q <= nxt.bytes;
      nl_q    <= nxt.nl;
      cut_q   <= nxt.cut;
    end
  end

endmodule

FILE: rtl/core/stt_fifo.sv
module stt_fifo #(
  parameter int unsigned Depth = stt_pkg::QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  stt_pkg::bundle_t wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output stt_pkg::bundle_t rdata_o
);
  import stt_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  bundle_t         mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      if (do_pop) rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= FullCnt)
    else $error("queue count overflow");
  a_push_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not grow");
  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push |-> wdata_i.cnt != 2'd0)
    else $error("empty bundle queued");

endmodule

FILE: rtl/core/stt_back.sv
module stt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  stt_pkg::bundle_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output stt_pkg::res_t    out_res_o
);
  import stt_pkg::*;

  logic idx_q, idx_d, last;

  assign out_valid_o = !empty_i;
  assign out_res_o   = head_i.res[idx_q];
  assign last        = (head_i.cnt == 2'd1) || idx_q;
  assign pop_o       = out_valid_o && out_ready_i && last;

  always_comb begin
    idx_d = idx_q;
    if (out_valid_o && out_ready_i) idx_d = !last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= 1'b0;
    else idx_q <= idx_d;
  end

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && idx_q) |-> head_i.cnt == 2'd2)
    else $error("slot index past bundle");
  a_idx_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> idx_q == $past(idx_q))
    else $error("slot index moved while stalled");
  a_pop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> !idx_q)
    else $error("slot index not cleared on pop");

endmodule

FILE: rtl/core/source_text_tokenizer_core.sv
// source text tokenizer
// slave stream: one transfer per character (s_tuser_i = 0, byte in s_tdata_i)
// or an end-of-input mark (s_tuser_i = 1). master stream: one transfer per
// token byte; m_tlast_o marks the last transfer of a token, class 6 closes input.
// config channel: cfg_index_i 0 = max token bytes, 1 = count lines; always ready,
// write only while idle.
// the scanner takes one character per cycle while the queue is not full and writes
// any results it causes (at most two) as one bundle into a small queue; the output
// side drains one result per cycle while the receiver is ready. a token byte appears
// one character late for runs (whitespace, letters, digits, line comments, slash),
// at once for strings and block comments; results are registered in the queue,
// whose head drives the output directly. sustained rate: one character per cycle
// while most characters yield at most one result; characters yielding two results
// need the single output port twice, which drains the queue one result at a time.
// reset clears the scanner, line count and queue and loads the register defaults.
// a stalled receiver holds m_tdata_o steady; once the queue fills, s_tready_o
// drops until a bundle drains.
module source_text_tokenizer_core #(
  parameter int unsigned QueueDepth = stt_pkg::QueueDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [stt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [stt_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [7:0]                    s_tdata_i,  // in_byte
  input  logic                          s_tuser_i,  // mode
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [39:0]                   m_tdata_o,  // out_byte, line_number
  output logic [4:0]                    m_tuser_o,  // byte_valid, token_class, truncated
  output logic                          m_tlast_o
);
  import stt_pkg::*;

  logic    push, full, pop, empty;
  bundle_t wbundle, head;
  res_t    res;

  assign cfg_ready_o = 1'b1;

  stt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_tvalid_i),
    .in_ready_o  (s_tready_o),
    .in_mode_i   (s_tuser_i),
    .in_byte_i   (s_tdata_i),
    .push_o      (push),
    .bundle_o    (wbundle),
    .full_i      (full)
  );

  stt_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wbundle),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (head)
  );

  stt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .out_res_o   (res)
  );

  assign m_tdata_o = {res.line_number, res.out_byte};
  assign m_tuser_o = {res.truncated, res.token_class, res.byte_valid};
  assign m_tlast_o = res.token_end;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import stt_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_tvalid_i = 1'b0;
  logic                s_tready_o;
  logic [7:0]          s_tdata_i = '0;  // in_byte
  logic                s_tuser_i = 1'b0;  // mode
  logic                m_tvalid_o;
  logic                m_tready_i = 1'b0;
  logic [39:0]         m_tdata_o;  // out_byte, line_number
  logic [4:0]          m_tuser_o;  // byte_valid, token_class, truncated
  logic                m_tlast_o;

  source_text_tokenizer_core u_top (.*);

  localparam int unsigned WatchdogLimit = 4000;

  typedef struct {
    logic       eoi;
    logic [7:0] ch;
    logic       typed;
    res_t       want;
  } dir_row_t;

  res_t expected_tokens[$];
  int   errors = 0;
  int   idle_cycles = 0;
  bit   hold_done = 1'b0;

  // scanner copy
  logic [15:0] max_bytes = MaxBytesReset;
  logic        lines_on = 1'b1;
  phase_e      phase = PH_IDLE;
  logic [7:0]  held_ch = '0;
  logic        held_v = 1'b0;
  class_e      held_cls = CL_SPACE;
  logic [7:0]  delim = '0;
  logic [15:0] nbytes = '0;
  logic [31:0] nl_total = '0;
  logic        cut = 1'b0;
  res_t        produced[$];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit sp(logic [7:0] b);
    return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
  endfunction
  function automatic bit al(logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction
  function automatic bit dg(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  task automatic emit(logic [7:0] b, logic v, class_e c, logic e);
    res_t r;
    r.out_byte = b;
    r.byte_valid = v;
    r.token_class = c;
    r.token_end = e;
    r.truncated = cut;
    r.line_number = nl_total;
    produced.push_back(r);
  endtask

  task automatic take(output bit ok);
    ok = nbytes < max_bytes;
    if (ok) nbytes++;
    else cut = 1'b1;
  endtask

  task automatic bump_line(logic [7:0] b);
    if (b == ChNewline && lines_on) nl_total++;
  endtask

  task automatic give(logic [7:0] b, logic e);
    bit ok;
    take(ok);
    if (ok) emit(b, 1'b1, held_cls, e);
    else if (e) emit(8'h00, 1'b0, held_cls, 1'b1);
  endtask

  task automatic grow(logic [7:0] b);
    bit ok;
    take(ok);
    if (ok) begin
      if (held_v) emit(held_ch, 1'b1, held_cls, 1'b0);
      held_ch = b;
      held_v = 1'b1;
    end
  endtask

  task automatic close_run();
    if (held_v) emit(held_ch, 1'b1, held_cls, 1'b1);
    else emit(8'h00, 1'b0, held_cls, 1'b1);
    held_v = 1'b0;
    phase = PH_IDLE;
  endtask

  task automatic open_token(logic [7:0] b);
    nbytes = '0;
    cut = 1'b0;
    held_v = 1'b0;
    if (sp(b) || al(b) || dg(b) || b == ChSlash) begin
      if (sp(b)) begin phase = PH_SPACE; held_cls = CL_SPACE; end
      else if (al(b)) begin phase = PH_ALPHA; held_cls = CL_ALPHA; end
      else if (dg(b)) begin phase = PH_DIGIT; held_cls = CL_DIGIT; end
      else begin phase = PH_SLASH; held_cls = CL_SINGLE; end
      grow(b);
      if (phase == PH_SPACE) bump_line(b);
    end else if (b == ChDquote || b == ChSquote) begin
      phase = PH_STR;
      held_cls = CL_STRING;
      delim = b;
      give(b, 1'b0);
    end else begin
      phase = PH_IDLE;
      held_cls = CL_SINGLE;
      give(b, 1'b1);
    end
  endtask

  task automatic tokenize(logic eoi, logic [7:0] b);
    produced.delete();
    if (eoi) begin
      case (phase)
        PH_SPACE, PH_ALPHA, PH_DIGIT, PH_SLASH, PH_LINE: close_run();
        PH_STR, PH_STR_ESC: give(delim, 1'b1);
        PH_BLOCK, PH_BLOCK_STAR: give(ChSlash, 1'b1);
        default: ;
      endcase
      phase = PH_IDLE;
      held_v = 1'b0;
      nbytes = '0;
      cut = 1'b0;
      emit(8'h00, 1'b0, CL_EOI, 1'b1);
      return;
    end
    case (phase)
      PH_SPACE: begin
        if (sp(b)) begin grow(b); bump_line(b); end
        else begin close_run(); open_token(b); end
      end
      PH_ALPHA: begin
        if (al(b)) grow(b);
        else begin close_run(); open_token(b); end
      end
      PH_DIGIT: begin
        if (dg(b)) grow(b);
        else begin close_run(); open_token(b); end
      end
      PH_LINE: begin
        if (b != ChNewline) grow(b);
        else begin close_run(); open_token(b); end
      end
      PH_SLASH: begin
        if (b == ChStar) begin
          held_cls = CL_COMMENT;
          if (held_v) emit(held_ch, 1'b1, held_cls, 1'b0);
          held_v = 1'b0;
          give(b, 1'b0);
          phase = PH_BLOCK;
        end else if (b == ChSlash) begin
          held_cls = CL_COMMENT;
          phase = PH_LINE;
          grow(b);
        end else begin
          close_run();
          open_token(b);
        end
      end
      PH_STR: begin
        if (b == delim) begin
          give(b, 1'b1);
          phase = PH_IDLE;
        end else begin
          give(b, 1'b0);
          if (b == ChBackslash) phase = PH_STR_ESC;
        end
      end
      PH_STR_ESC: begin
        give(b, 1'b0);
        phase = PH_STR;
      end
      PH_BLOCK: begin
        give(b, 1'b0);
        if (b == ChStar) phase = PH_BLOCK_STAR;
      end
      PH_BLOCK_STAR: begin
        if (b == ChSlash) begin
          give(b, 1'b1);
          phase = PH_IDLE;
        end else begin
          give(b, 1'b0);
          if (b != ChStar) phase = PH_BLOCK;
        end
      end
      default: open_token(b);
    endcase
  endtask

  task automatic report(string what, res_t got, res_t want);
    $write("mismatch %s: got byte %02h v%0b cls %0d end %0b cut %0b line %0d, ",
           what, got.out_byte, got.byte_valid, got.token_class, got.token_end,
           got.truncated, got.line_number);
    $display("want byte %02h v%0b cls %0d end %0b cut %0b line %0d",
             want.out_byte, want.byte_valid, want.token_class, want.token_end,
             want.truncated, want.line_number);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  task automatic send(logic eoi, logic [7:0] b);
    int g;
    g = pick_gap();
    if (g > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i <= eoi;
    s_tdata_i <= eoi ? 8'($urandom_range(0, 255)) : b;
    do @(posedge clk_i); while (!s_tready_o);
    tokenize(eoi, eoi ? 8'h00 : b);
    foreach (produced[i]) expected_tokens.push_back(produced[i]);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    s_tvalid_i <= 1'b0;
    wait (expected_tokens.size() == 0);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgMaxBytes) max_bytes = val;
    else lines_on = val[0];
  endtask

  function automatic logic [7:0] run_char(int kind);
    case (kind)
      0: begin
        case ($urandom_range(0, 3))
          0: return ChNewline;
          1: return 8'($urandom_range(9, 13));
          default: return 8'd32;
        endcase
      end
      1: return $urandom_range(0, 1) ? 8'($urandom_range("A", "Z"))
                                     : 8'($urandom_range("a", "z"));
      2: return 8'($urandom_range("0", "9"));
      default: begin
        case ($urandom_range(0, 9))
          0: return ChStar;
          1: return ChSlash;
          2: return ChBackslash;
          3: return ChNewline;
          4: return ChDquote;
          5: return ChSquote;
          default: return 8'($urandom_range(0, 255));
        endcase
      end
    endcase
  endfunction

  task automatic send_token(inout int cnt);
    int kind;
    int len;
    logic [7:0] q;
    logic [7:0] c;
    kind = $urandom_range(0, 9);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
    case (kind)
      0, 1, 2: begin
        repeat (len) begin send(1'b0, run_char(kind)); cnt++; end
      end
      3: begin
        q = $urandom_range(0, 1) ? ChDquote : ChSquote;
        send(1'b0, q); cnt++;
        repeat (len) begin
          c = run_char(3);
          if (c == q) c = "q";
          send(1'b0, c); cnt++;
          if (c == ChBackslash) begin send(1'b0, run_char(3)); cnt++; end
        end
        if ($urandom_range(0, 5) != 0) begin send(1'b0, q); cnt++; end
      end
      4: begin
        send(1'b0, ChSlash); send(1'b0, ChStar); cnt += 2;
        repeat (len) begin send(1'b0, run_char(3)); cnt++; end
        if ($urandom_range(0, 5) != 0) begin
          send(1'b0, ChStar); send(1'b0, ChSlash); cnt += 2;
        end
      end
      5: begin
        send(1'b0, ChSlash); send(1'b0, ChSlash); cnt += 2;
        repeat (len) begin
          c = run_char(3);
          if (c == ChNewline) c = "-";
          send(1'b0, c); cnt++;
        end
        send(1'b0, ChNewline); cnt++;
      end
      6: begin send(1'b0, ChSlash); cnt++; end
      7: begin send(1'b0, 8'($urandom_range(0, 255))); cnt++; end
      8: begin
        c = 8'($urandom_range(33, 126));
        send(1'b0, (al(c) || dg(c)) ? 8'h3b : c); cnt++;
      end
      default: begin
        if ($urandom_range(0, 2) == 0) send(1'b1, 8'h00);
        else send(1'b0, 8'($urandom_range(0, 255)));
        cnt++;
      end
    endcase
  endtask

  // sink
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got.out_byte = m_tdata_o[7:0];
      got.line_number = m_tdata_o[39:8];
      got.byte_valid = m_tuser_o[0];
      got.token_class = class_e'(m_tuser_o[3:1]);
      got.truncated = m_tuser_o[4];
      got.token_end = m_tlast_o;
      if (expected_tokens.size() == 0) begin
        want = '0;
        report("unexpected transfer", got, want);
      end else begin
        want = expected_tokens.pop_front();
        if (got !== want) report("token byte", got, want);
      end
    end
  end

  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && expected_tokens.size() > 3) begin
        hold_done = 1'b1;
        m_tready_i <= 1'b0;
        for (hold = 0; hold < 300; hold++) @(posedge clk_i);
      end
      hold = $urandom_range(0, 99);
      if (hold < 70) m_tready_i <= 1'b1;
      else if (hold < 95) begin
        m_tready_i <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        m_tready_i <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    logic [15:0] max_set[5];
    logic        line_set[5];
    res_t        last;
    int          cnt;
    rows = '{
      '{1'b0, "a", 1'b0, '0}, '{1'b0, "b", 1'b0, '0}, '{1'b0, " ", 1'b0, '0},
      '{1'b0, ChNewline, 1'b0, '0}, '{1'b0, "1", 1'b0, '0}, '{1'b0, "2", 1'b0, '0},
      '{1'b0, ChSlash, 1'b0, '0}, '{1'b0, ChStar, 1'b0, '0}, '{1'b0, "x", 1'b0, '0},
      '{1'b0, ChStar, 1'b0, '0}, '{1'b0, ChSlash, 1'b0, '0}, '{1'b0, ChSlash, 1'b0, '0},
      '{1'b0, ChSlash, 1'b0, '0}, '{1'b0, "c", 1'b0, '0}, '{1'b0, ChNewline, 1'b0, '0},
      '{1'b0, ChDquote, 1'b0, '0}, '{1'b0, ChBackslash, 1'b0, '0},
      '{1'b0, ChDquote, 1'b0, '0}, '{1'b0, ChSquote, 1'b0, '0},
      '{1'b0, ChDquote, 1'b0, '0}, '{1'b0, ChSlash, 1'b0, '0},
      '{1'b0, "#", 1'b1, '{"#", 1'b1, CL_SINGLE, 1'b1, 1'b0, 32'd0}},
      '{1'b0, 8'hff, 1'b1, '{8'hff, 1'b1, CL_SINGLE, 1'b1, 1'b0, 32'd0}},
      '{1'b0, 8'h00, 1'b1, '{8'h00, 1'b1, CL_SINGLE, 1'b1, 1'b0, 32'd0}},
      '{1'b1, 8'h00, 1'b1, '{8'h00, 1'b0, CL_EOI, 1'b1, 1'b0, 32'd0}}
    };
    max_set = '{16'd1, 16'd3, 16'd65535, 16'd2, 16'd4096};
    line_set = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      send(rows[i].eoi, rows[i].ch);
      if (rows[i].typed) begin
        last = produced[produced.size() - 1];
        last.line_number = '0;
        if (last !== rows[i].want) report("directed", last, rows[i].want);
      end
    end
    for (int p = 0; p < 5; p++) begin
      write_reg(CfgMaxBytes, max_set[p]);
      write_reg(CfgCountLines, line_set[p]);
      cnt = 0;
      while (cnt < 45) send_token(cnt);
      send(1'b1, 8'h00);
    end
    s_tvalid_i <= 1'b0;
    wait (expected_tokens.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
